// ===== rtl/core/edsc_pkg.sv =====
// ----------------------------------------------------------------------------
// edsc_pkg: shared types and constants of the distance core
// Result widths, the square-root stage word and output packing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edsc_pkg;

   // Width of the running sum of squares.
   localparam int SUM_W = 44;
   // Width of the floor square root of the sum.
   localparam int DIST_W = SUM_W / 2;
   // One root bit is resolved per cell.
   localparam int SQRT_CELLS = DIST_W;
   // Partial remainder width: it stays below 2^(DIST_W+2) before each trial.
   localparam int REM_W = DIST_W + 3;
   // Result word: sum_sq, then distance, zero filled to whole bytes.
   localparam int RSP_DW = ((SUM_W + DIST_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DW - SUM_W - DIST_W;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Word handed from cell to cell along the square-root chain.
   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  sum;
      logic              sat;
      logic [REM_W-1:0]  rem;
      logic [DIST_W-1:0] root;
   } sqrt_stage_type;

endpackage

// ===== rtl/core/euclidean_distance_stream_core.sv =====
// A last word passes the square register, then every square-root cell in order.
// Takes one coordinate pair per cycle; with one cell per root bit (22 cells), a new
// vector total can enter the chain every cycle while the output is not stalled.
// Reset: synchronous, active high; clears the running sum, pair count,
// saturation flag and every valid bit of the chain.
// ----------------------------------------------------------------------------
// euclidean_distance_stream_core: streaming squared distance and its root
// Accumulates squared coordinate differences per vector and reports the total,
// its floor square root and a saturation flag on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euclidean_distance_stream_core #(
   parameter int COORD_BITS = 16,
   parameter int MAX_DIMS   = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input word: [x_coord, y_coord] from bit 0 up, zero filled to bytes.
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,   // last_elem
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Result word: [sum_sq, distance] from bit 0 up, zero filled to bytes.
   output logic [edsc_pkg::RSP_DW-1:0]           rsp_tdata,
   output logic                                  rsp_tuser,   // saturated
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);
   import edsc_pkg::*;

   localparam int CHK_W = 2 * DIST_W + 2;

   sqrt_stage_type chain [0:SQRT_CELLS];
   logic           chain_en;
   sqrt_stage_type tail;

   // The whole root chain moves together; freeze it only while the final
   // cell holds a result the consumer has not taken.
   assign chain_en = !chain[SQRT_CELLS].valid || rsp_tready;

   // Front end: square, accumulate, hand vector totals to the chain. It keeps
   // taking words under an output stall until a last word must enter the chain.
   edsc_acc #(
      .COORD_BITS (COORD_BITS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .x_coord   (req_tdata[COORD_BITS-1:0]),
      .y_coord   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .last_elem (req_tlast),
      .chain_en  (chain_en),
      .chain_out (chain[0])
   );

   // One cell per root bit, most significant first.
   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_cell
      edsc_sqrt_cell #(
         .IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (chain_en),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // The last cell's register doubles as the output register.
   assign tail       = chain[SQRT_CELLS];
   assign rsp_tvalid = tail.valid;
   assign rsp_tdata  = {RSP_PAD_W'(0), tail.root, tail.sum};
   assign rsp_tuser  = tail.sat;

`ifndef SYNTHESIS
   a_root_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((CHK_W'(tail.root) * CHK_W'(tail.root)) <= CHK_W'(tail.sum)))
      else $error("distance too large for sum_sq");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (((CHK_W'(tail.root) + CHK_W'(1)) * (CHK_W'(tail.root) + CHK_W'(1)))
          > CHK_W'(tail.sum)))
      else $error("distance too small for sum_sq");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");
`endif

endmodule

// ===== rtl/core/edsc_acc.sv =====
// ----------------------------------------------------------------------------
// edsc_acc: squared-difference accumulator
// Squares each coordinate difference, keeps a saturating sum and pair count,
// and hands the total of a vector to the square-root chain on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edsc_acc #(
   parameter int COORD_BITS = 16,
   parameter int MAX_DIMS   = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [COORD_BITS-1:0]    x_coord,
   input  logic [COORD_BITS-1:0]    y_coord,
   input  logic                     last_elem,
   input  logic                     chain_en,
   output edsc_pkg::sqrt_stage_type chain_out
);
   import edsc_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int ACC_W  = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
   localparam int CNT_W  = $clog2(MAX_DIMS + 1);

   logic signed [DIFF_W-1:0] diff;
   logic        [DIFF_W-1:0] mag;
   logic        [SQ_W-1:0]   sq;

   logic                 a_valid_ff, a_valid_in;
   logic                 a_last_ff;
   logic [SQ_W-1:0]      a_sq_ff;

   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 flag_ff, flag_in;

   logic                 adv;
   logic                 take;
   logic                 emit;
   logic                 cnt_full;
   logic [ACC_W-1:0]     sum_ext;
   logic                 ovf;
   logic [SUM_W-1:0]     sum_new;
   logic                 flag_new;

   // Difference is exact in one extra bit; its magnitude never reaches 2^COORD_BITS.
   assign diff = $signed({x_coord[COORD_BITS-1], x_coord})
               - $signed({y_coord[COORD_BITS-1], y_coord});
   assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign sq   = SQ_W'(mag) * SQ_W'(mag);

   // Hold the square stage only when it carries a last word the chain cannot take.
   assign adv      = !a_valid_ff || !a_last_ff || chain_en;
   assign in_ready = adv;
   assign take     = in_valid && adv;
   assign emit     = a_valid_ff && a_last_ff && adv;

   assign a_valid_in = adv ? in_valid : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_sq_ff   <= sq;
         a_last_ff <= last_elem;
      end
   end

   // Saturating accumulate.
   assign cnt_full = (cnt_ff == CNT_W'(MAX_DIMS));
   assign sum_ext  = ACC_W'(sum_ff) + ACC_W'(a_sq_ff);
   assign ovf      = (sum_ext > ACC_W'(SUM_MAX));
   assign sum_new  = ovf ? SUM_MAX : sum_ext[SUM_W-1:0];
   assign flag_new = flag_ff || ovf || cnt_full;

   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      flag_in = flag_ff;
      if (a_valid_ff && adv) begin
         if (a_last_ff) begin
            sum_in  = '0;
            cnt_in  = '0;
            flag_in = 1'b0;
         end else begin
            sum_in  = sum_new;
            cnt_in  = cnt_full ? cnt_ff : cnt_ff + CNT_W'(1);
            flag_in = flag_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         flag_ff <= flag_in;
      end
   end

   always_comb begin
      chain_out.valid = emit;
      chain_out.sum   = sum_new;
      chain_out.sat   = flag_new;
      chain_out.rem   = '0;
      chain_out.root  = '0;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIMS))
      else $error("pair count ran past its limit");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (sum_ff == '0) && (cnt_ff == '0) && !flag_ff)
      else $error("vector state not cleared after last word");

   a_stall_on_last: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> a_valid_ff && a_last_ff)
      else $error("input stalled without a waiting last word");
`endif

endmodule

// ===== rtl/core/edsc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// edsc_sqrt_cell: one restoring square-root cell
// Brings in two radicand bits, tries one root bit, registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edsc_sqrt_cell #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  edsc_pkg::sqrt_stage_type stage_in,
   output edsc_pkg::sqrt_stage_type stage_out
);
   import edsc_pkg::*;

   localparam int PAIR_HI = SUM_W - 1 - 2 * IDX;

   sqrt_stage_type cell_ff, cell_in;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             ge;

   assign rem_sh = {stage_in.rem[REM_W-3:0], stage_in.sum[PAIR_HI -: 2]};
   assign trial  = REM_W'({stage_in.root, 2'b01});
   assign ge     = (rem_sh >= trial);

   always_comb begin
      cell_in      = stage_in;
      cell_in.rem  = ge ? (rem_sh - trial) : rem_sh;
      cell_in.root = {stage_in.root[DIST_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign stage_out = cell_ff;

endmodule
